[rtl/apsp_pkg.sv]
// Shared widths and stream packing constants for the antimeridian polygon splitter.
`default_nettype none

package apsp_pkg;

	// coordinate field widths
	localparam int LAT_W = 28;
	localparam int LON_W = 29;

	// stream packing
	localparam int TDATA_W = 64;
	localparam int TDATA_PAD = TDATA_W - LAT_W - LON_W;
	localparam int TUSER_W = 2;
	localparam int USER_SUB = 0;
	localparam int USER_RUN = 1;

endpackage

`default_nettype wire

[rtl/apsp_lerp.sv]
// Bit-serial border latitude unit: lat = clat + dlat * dc / (dc + dn), saturated.
`default_nettype none

module apsp_lerp #(
	parameter int WW = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [apsp_pkg::LAT_W-1:0]  clat,
	input  wire logic [apsp_pkg::LAT_W:0]    dlat,
	input  wire logic [WW-1:0]               dc,
	input  wire logic [WW-1:0]               dn,
	output logic                             done,
	output logic [apsp_pkg::LAT_W-1:0]       lat
);

	localparam int LW = apsp_pkg::LAT_W;
	localparam int MW = LW + 1;
	localparam int PW = MW + WW;
	localparam int SW = LW + 3;
	localparam int CW = $clog2(PW);
	localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (LW - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_PREP = 5'b00010,
		L_MUL  = 5'b00100,
		L_DIV  = 5'b01000,
		L_FIN  = 5'b10000
	} lerp_state_t;

	lerp_state_t       lstate_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [LW-1:0]     clat_q;
	logic [MW-1:0]     dlat_q;
	logic [WW-1:0]     dc_q;
	logic [WW-1:0]     total_q;
	logic [MW-1:0]     mcand_q;
	logic [WW-1:0]     dvsr_q;
	logic              neg_q;
	logic              zero_q;
	logic [PW-1:0]     prod_q;
	logic [WW-1:0]     rem_q;
	logic [MW-1:0]     quo_q;
	logic              ovf_q;
	logic [LW-1:0]     lat_q;

	logic [WW-1:0]     dc_mag;
	logic [WW-1:0]     total_mag;
	logic [MW-1:0]     dlat_mag;
	logic [MW:0]       mul_sum;
	logic [WW:0]       trial;
	logic [WW:0]       trial_diff;
	logic              fits;
	logic [SW-1:0]     q_ext;
	logic [SW-1:0]     q_sgn;
	logic [SW-1:0]     clat_ext;
	logic signed [SW-1:0] sum_s;
	logic [LW-1:0]     sat_lat;

	// magnitudes and signs of the operands
	always_comb begin
		dc_mag    = dc_q[WW-1] ? (~dc_q + WW'(1)) : dc_q;
		total_mag = total_q[WW-1] ? (~total_q + WW'(1)) : total_q;
		dlat_mag  = dlat_q[MW-1] ? (~dlat_q + MW'(1)) : dlat_q;
	end

	// shift-add multiply step, low multiplier bit first
	assign mul_sum = {1'b0, prod_q[PW-1:WW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	// restoring divide step, dividend enters msb first
	assign trial      = {rem_q, prod_q[PW-1]};
	assign fits       = (trial >= {1'b0, dvsr_q});
	assign trial_diff = trial - {1'b0, dvsr_q};

	// signed quotient, offset and clamp
	always_comb begin
		q_ext    = {{(SW - MW){1'b0}}, quo_q};
		q_sgn    = neg_q ? (~q_ext + SW'(1)) : q_ext;
		clat_ext = {{(SW - LW){clat_q[LW-1]}}, clat_q};
		sum_s    = $signed(clat_ext + q_sgn);
		if (ovf_q) begin
			sat_lat = neg_q ? SAT_LO[LW-1:0] : SAT_HI[LW-1:0];
		end else if (sum_s > SAT_HI) begin
			sat_lat = SAT_HI[LW-1:0];
		end else if (sum_s < SAT_LO) begin
			sat_lat = SAT_LO[LW-1:0];
		end else begin
			sat_lat = sum_s[LW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lstate_q <= L_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (lstate_q)
				L_IDLE: begin
					if (start) begin
						lstate_q <= L_PREP;
					end
				end
				L_PREP: begin
					cnt_q    <= CW'(WW - 1);
					lstate_q <= L_MUL;
				end
				L_MUL: begin
					if (cnt_q == '0) begin
						cnt_q    <= CW'(PW - 1);
						lstate_q <= L_DIV;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				L_DIV: begin
					if (cnt_q == '0) begin
						lstate_q <= L_FIN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				L_FIN: begin
					done_q   <= 1'b1;
					lstate_q <= L_IDLE;
				end
				default: begin
					lstate_q <= L_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (lstate_q)
			L_IDLE: begin
				if (start) begin
					clat_q  <= clat;
					dlat_q  <= dlat;
					dc_q    <= dc;
					total_q <= dc + dn;
				end
			end
			L_PREP: begin
				mcand_q <= dlat_mag;
				dvsr_q  <= total_mag;
				neg_q   <= dlat_q[MW-1] ^ dc_q[WW-1] ^ total_q[WW-1];
				zero_q  <= (total_q == '0);
				prod_q  <= {{MW{1'b0}}, dc_mag};
				rem_q   <= '0;
				quo_q   <= '0;
				ovf_q   <= 1'b0;
			end
			L_MUL: begin
				prod_q <= {mul_sum, prod_q[WW-1:1]};
			end
			L_DIV: begin
				rem_q  <= fits ? trial_diff[WW-1:0] : trial[WW-1:0];
				prod_q <= {prod_q[PW-2:0], 1'b0};
				quo_q  <= {quo_q[MW-2:0], fits};
				ovf_q  <= ovf_q | quo_q[MW-1];
			end
			L_FIN: begin
				lat_q <= zero_q ? clat_q : sat_lat;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign lat  = lat_q;

endmodule

`default_nettype wire

[rtl/antimeridian_polygon_splitter_top.sv]
// Top level: edge sequencer, border handling and output register of the polygon splitter.
//
//  channel   dir  handshake                  payload
//  s_*       in   s_tvalid / s_tready        tdata: vertex_lat, vertex_lon; tlast: last_vertex
//  m_*       out  m_tvalid / m_tready        tdata: point_lat, point_lon; tlast: polygon_end;
//                                            tuser: sub_polygon, run_end
//
// A vertex is taken only while the sequencer is idle. An edge passes a setup state and then
// emits its points; an edge that crosses the antimeridian also runs the bit-serial border
// unit, a multiply phase and then a divide phase, before its two border points are emitted.
// Reset clears the sequencer and the held-vertex flag.
// A stalled output holds the next point in the sequencer; a new vertex may be taken while the
// last point still waits in the output register.
`default_nettype none

module antimeridian_polygon_splitter_top #(
	parameter int FRAC_BITS = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [27:0] vertex_lat, [56:28] vertex_lon, [63:57] zero
	input  wire logic [apsp_pkg::TDATA_W-1:0]  s_tdata,
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [27:0] point_lat, [56:28] point_lon, [63:57] zero
	output logic [apsp_pkg::TDATA_W-1:0]       m_tdata,
	// [0] sub_polygon, [1] run_end
	output logic [apsp_pkg::TUSER_W-1:0]       m_tuser,
	output logic                               m_tlast
);

	localparam int LW = apsp_pkg::LAT_W;
	localparam int OW = apsp_pkg::LON_W;
	localparam int WW = ((FRAC_BITS + 8 > OW) ? FRAC_BITS + 8 : OW) + 3;
	localparam logic [WW-1:0] D180  = WW'(180) << FRAC_BITS;
	localparam logic [WW-1:0] D90   = WW'(90) << FRAC_BITS;
	localparam logic [WW-1:0] DM180 = ~D180 + WW'(1);
	localparam logic [OW-1:0] BPOS  = D180[OW-1:0];
	localparam logic [OW-1:0] BNEG  = DM180[OW-1:0];

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_START = 6'b000100,
		S_LERP  = 6'b001000,
		S_B1    = 6'b010000,
		S_B2    = 6'b100000
	} state_t;

	state_t         state_q;
	logic           have_prev_q;
	logic           poly_q;
	logic           pend_close_q;
	logic           edge_close_q;
	logic           wrap_q;
	logic           east_q;

	logic [LW-1:0]  first_lat_q;
	logic [OW-1:0]  first_lon_q;
	logic [LW-1:0]  prev_lat_q;
	logic [OW-1:0]  prev_lon_q;
	logic [LW-1:0]  clat_q;
	logic [OW-1:0]  clon_q;
	logic [LW-1:0]  nlat_q;
	logic [OW-1:0]  nlon_q;
	logic [LW:0]    dlat_q;
	logic [WW-1:0]  dc_q;
	logic [WW-1:0]  dn_q;
	logic [LW-1:0]  blat_q;

	logic           m_tvalid_q;
	logic [LW-1:0]  out_lat_q;
	logic [OW-1:0]  out_lon_q;
	logic           out_sub_q;
	logic           out_run_q;
	logic           out_poly_q;

	logic [LW-1:0]  in_lat;
	logic [OW-1:0]  in_lon;
	logic           accept;

	logic signed [WW-1:0] clon_w;
	logic signed [WW-1:0] nlon_w;
	logic signed [WW-1:0] diff_w;
	logic [WW-1:0]        absd_w;
	logic                 wrap_c;
	logic                 east_c;
	logic [WW-1:0]        dc_c;
	logic [WW-1:0]        dn_c;
	logic [LW:0]          dlat_c;

	logic           can_emit;
	logic           emit;
	logic           last_of_edge;
	logic           edge_done;
	logic [LW-1:0]  e_lat;
	logic [OW-1:0]  e_lon;
	logic           e_run;
	logic           e_poly;
	logic           lerp_start;
	logic           lerp_done;
	logic [LW-1:0]  lerp_lat;

	assign in_lat   = s_tdata[LW-1:0];
	assign in_lon   = s_tdata[LW+OW-1:LW];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// edge classification and border spans
	always_comb begin
		clon_w = $signed({{(WW - OW){clon_q[OW-1]}}, clon_q});
		nlon_w = $signed({{(WW - OW){nlon_q[OW-1]}}, nlon_q});
		diff_w = nlon_w - clon_w;
		absd_w = diff_w[WW-1] ? (~diff_w + WW'(1)) : diff_w;
		wrap_c = (absd_w > D180);
		east_c = (clon_w > $signed(D90));
		dc_c   = east_c ? (D180 - clon_w) : (D180 + clon_w);
		dn_c   = east_c ? (D180 + nlon_w) : (D180 - nlon_w);
		dlat_c = {nlat_q[LW-1], nlat_q} - {clat_q[LW-1], clat_q};
	end

	// point selection for the output register
	always_comb begin
		can_emit     = !m_tvalid_q || m_tready;
		emit         = 1'b0;
		last_of_edge = 1'b0;
		e_lat        = clat_q;
		e_lon        = clon_q;
		case (state_q)
			S_START: begin
				emit         = can_emit;
				last_of_edge = !wrap_q;
			end
			S_B1: begin
				emit  = can_emit;
				e_lat = blat_q;
				e_lon = east_q ? BPOS : BNEG;
			end
			S_B2: begin
				emit         = can_emit;
				last_of_edge = 1'b1;
				e_lat        = blat_q;
				e_lon        = east_q ? BNEG : BPOS;
			end
			default: begin
			end
		endcase
		e_run      = last_of_edge && !pend_close_q;
		e_poly     = e_run && edge_close_q;
		edge_done  = emit && last_of_edge;
		lerp_start = (state_q == S_START) && can_emit && wrap_q;
	end

	// edge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			have_prev_q  <= 1'b0;
			poly_q       <= 1'b0;
			pend_close_q <= 1'b0;
			edge_close_q <= 1'b0;
			wrap_q       <= 1'b0;
			east_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q  <= !s_tlast;
						pend_close_q <= have_prev_q && s_tlast;
						edge_close_q <= !have_prev_q;
						if (have_prev_q || s_tlast) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					wrap_q  <= wrap_c;
					east_q  <= east_c;
					state_q <= S_START;
				end
				S_START: begin
					if (lerp_start) begin
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_done) begin
						state_q <= S_B1;
					end
				end
				S_B1: begin
					if (emit) begin
						poly_q  <= ~poly_q;
						state_q <= S_B2;
					end
				end
				S_B2: begin
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// closing edge follows, or the request is finished
			if (edge_done) begin
				if (pend_close_q) begin
					pend_close_q <= 1'b0;
					edge_close_q <= 1'b1;
					state_q      <= S_SETUP;
				end else begin
					state_q <= S_IDLE;
					if (edge_close_q) begin
						poly_q <= 1'b0;
					end
				end
			end
		end
	end

	// vertex and edge payload
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_lat_q <= in_lat;
			prev_lon_q <= in_lon;
			if (!have_prev_q) begin
				first_lat_q <= in_lat;
				first_lon_q <= in_lon;
				clat_q      <= in_lat;
				clon_q      <= in_lon;
			end else begin
				clat_q <= prev_lat_q;
				clon_q <= prev_lon_q;
			end
			nlat_q <= in_lat;
			nlon_q <= in_lon;
		end
		if (edge_done && pend_close_q) begin
			clat_q <= prev_lat_q;
			clon_q <= prev_lon_q;
			nlat_q <= first_lat_q;
			nlon_q <= first_lon_q;
		end
		if (state_q == S_SETUP) begin
			dc_q   <= dc_c;
			dn_q   <= dn_c;
			dlat_q <= dlat_c;
		end
		if ((state_q == S_LERP) && lerp_done) begin
			blat_q <= lerp_lat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_lat_q  <= e_lat;
			out_lon_q  <= e_lon;
			out_sub_q  <= poly_q;
			out_run_q  <= e_run;
			out_poly_q <= e_poly;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{apsp_pkg::TDATA_PAD{1'b0}}, out_lon_q, out_lat_q};
	assign m_tlast  = out_poly_q;
	always_comb begin
		m_tuser                     = '0;
		m_tuser[apsp_pkg::USER_SUB] = out_sub_q;
		m_tuser[apsp_pkg::USER_RUN] = out_run_q;
	end

	// border latitude unit
	apsp_lerp #(
		.WW(WW)
	) u_lerp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.clat  (clat_q),
		.dlat  (dlat_q),
		.dc    (dc_q),
		.dn    (dn_q),
		.done  (lerp_done),
		.lat   (lerp_lat)
	);

	// checks
	a_lerp_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_start |=> state_q == S_LERP)
		else $error("border unit started outside edge start");

	a_lerp_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> state_q == S_LERP)
		else $error("border result arrived while not waiting");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten while stalled");

	a_polygon_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_poly) |=> (!poly_q && !have_prev_q && state_q == S_IDLE))
		else $error("polygon state not cleared after closing edge");

endmodule

`default_nettype wire

[tb/polygon_split_checker.sv]
// Checker for the polygon splitter: predicts emitted points per accepted vertex and compares.
module polygon_split_checker #(
	parameter int FRAC_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// [27:0] vertex_lat, [56:28] vertex_lon, [63:57] zero
	input  logic [apsp_pkg::TDATA_W-1:0]      s_tdata,
	input  logic                              s_tlast,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// [27:0] point_lat, [56:28] point_lon, [63:57] zero
	input  logic [apsp_pkg::TDATA_W-1:0]      m_tdata,
	// [0] sub_polygon, [1] run_end
	input  logic [apsp_pkg::TUSER_W-1:0]      m_tuser,
	input  logic                              m_tlast,
	output int                                fail_count,
	output int                                pending
);
	import apsp_pkg::*;

	localparam longint HALF_TURN = longint'(180) <<< FRAC_BITS;
	localparam longint QUARTER_TURN = longint'(90) <<< FRAC_BITS;
	localparam longint LAT_TOP = (longint'(1) <<< (LAT_W - 1)) - 1;
	localparam longint LAT_BOT = -(longint'(1) <<< (LAT_W - 1));

	typedef struct packed {
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		logic             sub;
		logic             run_end;
		logic             poly_end;
	} point_t;

	point_t expected_points[$];
	point_t step_points[$];

	// predictor state: ring start, last vertex seen, open ring flag, current sub-polygon
	longint ring_start_lat, ring_start_lon;
	longint last_seen_lat, last_seen_lon;
	logic   ring_open = 1'b0;
	logic   side = 1'b0;
	int     points_seen = 0;

	function automatic void emit_point(input longint lat, input longint lon, input logic sub);
		point_t p;
		p.lat = lat[LAT_W-1:0];
		p.lon = lon[LON_W-1:0];
		p.sub = sub;
		p.run_end = 1'b0;
		p.poly_end = 1'b0;
		step_points.push_back(p);
	endfunction

	// one edge: start vertex, plus a border point pair when it wraps around the seam
	function automatic void trace_edge(input longint clat, input longint clon,
	                                   input longint nlat, input longint nlon);
		longint span, dc, dn, total, blat;
		logic east;
		span = nlon - clon;
		if (span < 0)
			span = -span;
		emit_point(clat, clon, side);
		if (span > HALF_TURN) begin
			east = clon > QUARTER_TURN;
			dc = east ? HALF_TURN - clon : HALF_TURN + clon;
			dn = east ? HALF_TURN + nlon : HALF_TURN - nlon;
			total = dc + dn;
			blat = clat;
			// zero span keeps the start latitude
			if (total != 0)
				blat = clat + ((nlat - clat) * dc) / total;
			if (blat > LAT_TOP)
				blat = LAT_TOP;
			if (blat < LAT_BOT)
				blat = LAT_BOT;
			emit_point(blat, east ? HALF_TURN : -HALF_TURN, side);
			side = ~side;
			emit_point(blat, east ? -HALF_TURN : HALF_TURN, side);
		end
	endfunction

	function automatic void predict_vertex(input longint lat, input longint lon,
	                                       input logic last_one);
		int k;
		step_points.delete();
		if (!ring_open) begin
			ring_start_lat = lat;
			ring_start_lon = lon;
			ring_open = 1'b1;
		end else begin
			trace_edge(last_seen_lat, last_seen_lon, lat, lon);
		end
		last_seen_lat = lat;
		last_seen_lon = lon;
		// closing edge back to the ring start, then a fresh polygon
		if (last_one) begin
			trace_edge(lat, lon, ring_start_lat, ring_start_lon);
			ring_open = 1'b0;
			side = 1'b0;
		end
		if (step_points.size() > 0) begin
			k = step_points.size() - 1;
			step_points[k].run_end = 1'b1;
			step_points[k].poly_end = last_one;
		end
		foreach (step_points[i])
			expected_points.push_back(step_points[i]);
	endfunction

	task automatic log_mismatch(input string what, input logic [63:0] got,
	                            input logic [63:0] want);
		$display("mismatch at point %0d: %s got %0h, expected %0h", points_seen, what, got, want);
		fail_count++;
	endtask

	task automatic check_point();
		point_t want;
		if (expected_points.size() == 0) begin
			log_mismatch("point with none expected", m_tdata, '0);
			points_seen++;
			return;
		end
		want = expected_points.pop_front();
		if (m_tdata[LAT_W-1:0] !== want.lat)
			log_mismatch("point_lat", m_tdata[LAT_W-1:0], want.lat);
		if (m_tdata[LAT_W+LON_W-1:LAT_W] !== want.lon)
			log_mismatch("point_lon", m_tdata[LAT_W+LON_W-1:LAT_W], want.lon);
		if (m_tdata[TDATA_W-1:LAT_W+LON_W] !== '0)
			log_mismatch("tdata pad", m_tdata[TDATA_W-1:LAT_W+LON_W], '0);
		if (m_tuser[USER_SUB] !== want.sub)
			log_mismatch("sub_polygon", m_tuser[USER_SUB], want.sub);
		if (m_tuser[USER_RUN] !== want.run_end)
			log_mismatch("run_end", m_tuser[USER_RUN], want.run_end);
		if (m_tlast !== want.poly_end)
			log_mismatch("polygon_end", m_tlast, want.poly_end);
		points_seen++;
	endtask

	// output side is checked before the new vertex is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_points.delete();
			ring_open = 1'b0;
			side = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_point();
			if (s_tvalid && s_tready)
				predict_vertex(longint'($signed(s_tdata[LAT_W-1:0])),
				               longint'($signed(s_tdata[LAT_W+LON_W-1:LAT_W])), s_tlast);
			pending = expected_points.size();
		end
	end

endmodule

[tb/tb_antimeridian_polygon_splitter_top.sv]
// Testbench top for the polygon splitter: reset, vertex stimulus, output backpressure, verdict.
module tb_antimeridian_polygon_splitter_top;
	import apsp_pkg::*;

	localparam int FRAC_BITS = 20;
	localparam int LAT_RANGE = 90 << FRAC_BITS;
	localparam int LON_RANGE = 180 << FRAC_BITS;
	localparam int LAT_MAX = (1 << (LAT_W - 1)) - 1;
	localparam int LAT_MIN = -(1 << (LAT_W - 1));
	localparam int LON_MAX = (1 << (LON_W - 1)) - 1;
	localparam int LON_MIN = -(1 << (LON_W - 1));
	localparam int ITEM_TARGET = 230;
	localparam int CALM_FROM = 195;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;

	typedef enum int {LON_ANY, LON_NEAR_SEAM, LON_SEAM, LON_NOISE} lon_mode_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 m_tlast;

	int fail_count;
	int pending;
	int items_sent = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_request = 1'b0;

	antimeridian_polygon_splitter_top #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	polygon_split_checker #(.FRAC_BITS(FRAC_BITS)) split_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output backpressure: short random stalls, one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic int deg(input int d);
		return d * (1 << FRAC_BITS);
	endfunction

	function automatic int pick_lat(input bit noise);
		if (noise)
			return int'($urandom);
		return int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE;
	endfunction

	function automatic int pick_lon(input lon_mode_t mode);
		int mag;
		mag = 0;
		case (mode)
			LON_NOISE: return int'($urandom);
			LON_SEAM: mag = LON_RANGE;
			LON_NEAR_SEAM: mag = LON_RANGE - int'($urandom_range(0, deg(30)));
			default: return int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE;
		endcase
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	// offer one vertex request, optionally after an idle burst, and wait for acceptance
	task automatic send_vertex(input int lat, input int lon, input bit last_one);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{TDATA_PAD{1'b0}}, LON_W'(lon), LAT_W'(lat)};
		s_tlast <= last_one;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// random polygon, most vertices near the seam so edges wrap often; a noisy one gives many vertices random bits
	task automatic send_polygon(input int count, input bit noisy);
		int i;
		int roll;
		lon_mode_t mode;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 9);
			if (noisy && roll < 4)
				mode = LON_NOISE;
			else if (roll < 6)
				mode = LON_NEAR_SEAM;
			else if (roll == 6)
				mode = LON_SEAM;
			else
				mode = LON_ANY;
			send_vertex(pick_lat(noisy && $urandom_range(0, 1)), pick_lon(mode), i == count - 1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-vertex polygons, including field extremes
		send_vertex(0, 0, 1'b1);
		send_vertex(LAT_MAX, LON_MAX, 1'b1);
		send_vertex(LAT_MIN, LON_MIN, 1'b1);
		// eastward crossing triangle
		send_vertex(deg(10), deg(170), 1'b0);
		send_vertex(deg(20), deg(-170), 1'b0);
		send_vertex(deg(-5), deg(175), 1'b1);
		// both edges exactly on the seam: zero span
		send_vertex(deg(5), deg(180), 1'b0);
		send_vertex(deg(7), deg(-180), 1'b1);
		// out-of-range longitude drives the border latitude into saturation, both signs
		send_vertex(LAT_MAX, deg(255), 1'b0);
		send_vertex(LAT_MIN, 0, 1'b1);
		send_vertex(LAT_MIN, deg(255), 1'b0);
		send_vertex(LAT_MAX, 0, 1'b1);
		// westward crossing triangle
		send_vertex(deg(-30), deg(-170), 1'b0);
		send_vertex(deg(-40), deg(170), 1'b0);
		send_vertex(deg(-35), deg(-160), 1'b1);
		// start longitude exactly 90 goes to the -180 side
		send_vertex(0, deg(90), 1'b0);
		send_vertex(deg(10), deg(-100), 1'b1);
		// poles
		send_vertex(deg(90), deg(-179), 1'b0);
		send_vertex(deg(-90), deg(179), 1'b0);
		send_vertex(deg(45), 0, 1'b1);

		// long receiver hold while vertices keep coming, so the input backs up
		gaps_on = 1'b0;
		hold_request = 1'b1;
		send_polygon(6, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= CALM_FROM) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on = $urandom_range(0, 3) != 0;
				stalls_on = $urandom_range(0, 3) != 0;
			end
			send_polygon($urandom_range(1, 8), $urandom_range(0, 4) == 0);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/apsp_pkg.sv
rtl/apsp_lerp.sv
rtl/antimeridian_polygon_splitter_top.sv
tb/polygon_split_checker.sv
tb/tb_antimeridian_polygon_splitter_top.sv
